// ----- src/ipf_pkg.sv -----
// Shared types and constants for the sample-stream to MFM encoder.
// Used by every module of the block and by the port checker.
`timescale 1ns / 1ps

package ipf_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_COUNT   = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        K_MARK     = 3'd0,
        K_WORD     = 3'd1,
        K_END      = 3'd2,
        K_BADSIZE  = 3'd3,
        K_ZEROSIZE = 3'd4,
        K_SKIP     = 3'd5
    } t_kind;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int TYPE_W  = 5;
    localparam int KIND_W  = 3;
    localparam int SIZE_W  = 3;
    localparam int COUNT_W = 32;

    localparam logic [TYPE_W-1:0] TYPE_END  = 5'd0;
    localparam logic [TYPE_W-1:0] TYPE_MARK = 5'd1;
    localparam logic [TYPE_W-1:0] TYPE_DATA = 5'd2;
    localparam logic [TYPE_W-1:0] TYPE_GAP  = 5'd3;

    localparam logic [SIZE_W-1:0] SIZE_NONE = 3'd0;
    localparam logic [SIZE_W-1:0] SIZE_ONE  = 3'd1;
    localparam logic [SIZE_W-1:0] SIZE_TWO  = 3'd2;
    localparam logic [SIZE_W-1:0] SIZE_FOUR = 3'd4;

endpackage

// ----- src/ipf_mfm_enc.sv -----
// MFM encoder for one data byte: 16 cells, first cell in bit 15.
// Depends on ipf_pkg for widths.
`timescale 1ns / 1ps

module ipf_mfm_enc (
    input  logic [ipf_pkg::BYTE_W-1:0] i_data,
    input  logic                       i_prev_bit,
    output logic [ipf_pkg::WORD_W-1:0] o_word
);
    import ipf_pkg::*;

    logic [BYTE_W:0] w_bits;

    assign w_bits = {i_data, i_prev_bit};

    // Data cell is the bit; clock cell is set only between two zero bits.
    always_comb begin
        o_word = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            o_word[2*i]   = w_bits[i+1];
            o_word[2*i+1] = ~w_bits[i+1] & ~w_bits[i+2 > BYTE_W ? BYTE_W : i+2];
        end
        o_word[2*BYTE_W-1] = ~i_data[BYTE_W-1] & ~i_prev_bit;
    end

endmodule

// ----- src/ipf_sample_stream_to_mfm.sv -----
// Top level of the sample-stream to MFM encoder: header/count/payload parser,
// MFM encoding and the result register. Depends on ipf_pkg and ipf_mfm_enc.
// The block takes one stream byte per cycle and gives at most one result per
// byte, in the cycle after the byte is taken. Parsing and encoding sit
// between the parser state and a single result register, so bytes may arrive
// on every cycle; the input stalls only while a result is held by a stalled
// output. A stream_start byte resets the parser and clears a halt.
`timescale 1ns / 1ps

module ipf_sample_stream_to_mfm (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [ipf_pkg::BYTE_W-1:0] i_in_byte,
    input  logic                       i_stream_start,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [ipf_pkg::KIND_W-1:0] o_kind,
    output logic [ipf_pkg::WORD_W-1:0] o_word,
    output logic [ipf_pkg::TYPE_W-1:0] o_sample_kind
);
    import ipf_pkg::*;

    t_phase               r_phase, n_phase, w_phase;
    logic [TYPE_W-1:0]    r_type, n_type, w_type;
    logic [SIZE_W-1:0]    r_cnt, n_cnt, w_cnt;
    logic [COUNT_W-1:0]   r_pl, n_pl, w_pl;
    logic                 r_ldb, n_ldb, w_ldb;
    logic                 r_halt, n_halt, w_halt;

    logic                 r_out_valid;
    logic [KIND_W-1:0]    r_kind;
    logic [WORD_W-1:0]    r_word;
    logic [TYPE_W-1:0]    r_sk;

    logic                 n_res_valid;
    t_kind                n_res_kind;
    logic [WORD_W-1:0]    n_res_word;

    logic                 w_accept;
    logic [SIZE_W-1:0]    w_size;
    logic [COUNT_W-1:0]   w_pl_shift;
    logic [COUNT_W-1:0]   w_pl_dec;
    logic [SIZE_W-1:0]    w_cnt_dec;
    logic [WORD_W-1:0]    w_mfm;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    // State as seen by this byte, after an optional stream restart.
    assign w_phase = i_stream_start ? PH_HEADER : r_phase;
    assign w_type  = i_stream_start ? TYPE_END  : r_type;
    assign w_cnt   = i_stream_start ? '0 : r_cnt;
    assign w_pl    = i_stream_start ? '0 : r_pl;
    assign w_ldb   = i_stream_start ? 1'b0 : r_ldb;
    assign w_halt  = i_stream_start ? 1'b0 : r_halt;

    assign w_size     = i_in_byte[BYTE_W-1 -: SIZE_W];
    assign w_pl_shift = {w_pl[COUNT_W-BYTE_W-1:0], i_in_byte};
    assign w_pl_dec   = w_pl - COUNT_W'(1);
    assign w_cnt_dec  = w_cnt - SIZE_W'(1);

    ipf_mfm_enc u_enc (
        .i_data     (i_in_byte),
        .i_prev_bit (w_ldb),
        .o_word     (w_mfm)
    );

    // Next parser state
    always_comb begin
        n_phase = r_phase;
        n_type  = r_type;
        n_cnt   = r_cnt;
        n_pl    = r_pl;
        n_ldb   = r_ldb;
        n_halt  = r_halt;
        if (w_accept) begin
            n_phase = w_phase;
            n_type  = w_type;
            n_cnt   = w_cnt;
            n_pl    = w_pl;
            n_ldb   = w_ldb;
            n_halt  = w_halt;
            if (!w_halt) begin
                unique case (w_phase)
                    PH_COUNT: begin
                        n_pl  = w_pl_shift;
                        n_cnt = w_cnt_dec;
                        if (w_cnt_dec == '0) begin
                            n_phase = (w_pl_shift != '0) ? PH_PAYLOAD : PH_HEADER;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_pl = w_pl_dec;
                        if (w_pl_dec == '0) begin
                            n_phase = PH_HEADER;
                        end
                        if (w_type == TYPE_MARK || w_type == TYPE_DATA
                                || w_type == TYPE_GAP) begin
                            n_ldb = i_in_byte[0];
                        end
                    end
                    PH_HEADER: begin
                        n_type  = i_in_byte[TYPE_W-1:0];
                        n_pl    = '0;
                        n_cnt   = '0;
                        n_phase = PH_HEADER;
                        if (w_size == SIZE_NONE) begin
                            n_halt = (i_in_byte[TYPE_W-1:0] != TYPE_END);
                        end else if (w_size == SIZE_ONE || w_size == SIZE_TWO
                                || w_size == SIZE_FOUR) begin
                            n_cnt   = w_size;
                            n_phase = PH_COUNT;
                        end else begin
                            n_halt = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_HEADER;
                    end
                endcase
            end
        end
    end

    // Result for this byte
    always_comb begin
        n_res_valid = 1'b0;
        n_res_kind  = K_MARK;
        n_res_word  = '0;
        if (!w_halt) begin
            unique case (w_phase)
                PH_COUNT: begin
                    if (w_cnt_dec == '0) begin
                        if (w_type == TYPE_END) begin
                            n_res_valid = 1'b1;
                            n_res_kind  = K_END;
                        end else if (w_type > TYPE_GAP) begin
                            n_res_valid = 1'b1;
                            n_res_kind  = K_SKIP;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (w_type == TYPE_MARK) begin
                        n_res_valid = 1'b1;
                        n_res_kind  = K_MARK;
                        n_res_word  = {{(WORD_W-BYTE_W){1'b0}}, i_in_byte};
                    end else if (w_type == TYPE_DATA || w_type == TYPE_GAP) begin
                        n_res_valid = 1'b1;
                        n_res_kind  = K_WORD;
                        n_res_word  = w_mfm;
                    end
                end
                PH_HEADER: begin
                    n_res_valid = 1'b1;
                    if (w_size == SIZE_NONE) begin
                        n_res_kind = (i_in_byte[TYPE_W-1:0] == TYPE_END) ? K_END
                                                                         : K_ZEROSIZE;
                    end else if (w_size == SIZE_ONE || w_size == SIZE_TWO
                            || w_size == SIZE_FOUR) begin
                        n_res_valid = 1'b0;
                    end else begin
                        n_res_kind = K_BADSIZE;
                    end
                end
                default: begin
                    n_res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_type      <= '0;
            r_cnt       <= '0;
            r_pl        <= '0;
            r_ldb       <= 1'b0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_cnt   <= n_cnt;
            r_pl    <= n_pl;
            r_ldb   <= n_ldb;
            r_halt  <= n_halt;
            if (w_accept) begin
                r_out_valid <= n_res_valid;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the result payload only with a new result
    always_ff @(posedge i_clk) begin
        if (w_accept && n_res_valid) begin
            r_kind <= n_res_kind;
            r_word <= n_res_word;
            r_sk   <= n_type;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_word        = r_word;
    assign o_sample_kind = r_sk;

endmodule

// ----- src/ipf_checker.sv -----
// Port-level checker for the sample-stream to MFM encoder, bound to the top.
// Depends on ipf_pkg for result codes and widths.
`timescale 1ns / 1ps

module ipf_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       o_out_valid,
    input  logic                       i_out_stall,
    input  logic [ipf_pkg::KIND_W-1:0] o_kind,
    input  logic [ipf_pkg::WORD_W-1:0] o_word
);
    import ipf_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_word) && $stable(o_kind))
        else $error("stalled result dropped or changed");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_kind <= KIND_W'(K_SKIP))
        else $error("result kind out of range");

    a_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_W'(K_MARK) && o_kind != KIND_W'(K_WORD)
            |-> o_word == '0)
        else $error("status result carries a nonzero word");

    a_mfm_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_W'(K_WORD) |-> (o_word & (o_word >> 1)) == '0)
        else $error("encoded word has adjacent set cells");

endmodule

bind ipf_sample_stream_to_mfm ipf_checker u_ipf_checker (.*);

// ----- test/ipf_sample_stream_to_mfm_test.sv -----
// Self-checking testbench for ipf_sample_stream_to_mfm: drives a directed table and random
// sample streams, predicts every result in-line and checks the output field by field.
// Depends on ipf_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module ipf_sample_stream_to_mfm_test;
    import ipf_pkg::*;

    localparam int ITEM_TARGET  = 1350;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_CAP    = 50;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              start;
        logic              fixed;
        logic              has_result;
        t_kind             kind;
        logic [WORD_W-1:0] word;
        logic [TYPE_W-1:0] stype;
    } t_request;

    typedef struct packed {
        t_kind             kind;
        logic [WORD_W-1:0] word;
        logic [TYPE_W-1:0] stype;
    } t_result;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_stall;
    logic [BYTE_W-1:0] i_in_byte      = '0;
    logic              i_stream_start = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall    = 1'b0;
    logic [KIND_W-1:0] o_kind;
    logic [WORD_W-1:0] o_word;
    logic [TYPE_W-1:0] o_sample_kind;

    t_request req_cur = '0;
    t_request dir_table[$];
    t_result  mfm_expect_q[$];

    // Predictor state
    t_phase             pr_phase        = PH_HEADER;
    logic [TYPE_W-1:0]  pr_type         = '0;
    logic [SIZE_W-1:0]  pr_count_left   = '0;
    logic [COUNT_W-1:0] pr_payload_left = '0;
    logic               pr_last_bit     = 1'b0;
    logic               pr_halted       = 1'b0;

    int errors     = 0;
    int n_sent     = 0;
    int n_noise    = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int kind_seen[6];
    int cycles     = 0;
    int stall_left = 0;
    logic need_restart = 1'b0;
    logic in_calm      = 1'b0;
    logic out_calm     = 1'b0;

    ipf_sample_stream_to_mfm u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .i_stream_start (i_stream_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_word         (o_word),
        .o_sample_kind  (o_sample_kind)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [WORD_W-1:0] mfm_word(input logic [BYTE_W-1:0] d, input logic prev);
        logic [WORD_W-1:0] w;
        logic              p;
        w = '0;
        p = prev;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            // clock cell set only between two zero data bits
            w = {w[WORD_W-3:0], d[i] ? 2'b01 : (p ? 2'b00 : 2'b10)};
            p = d[i];
        end
        return w;
    endfunction

    function automatic logic mfm_predict_byte(input logic [BYTE_W-1:0] d, input logic start,
                                              output t_result r);
        logic [SIZE_W-1:0] size;
        r = '0;
        if (start) begin
            pr_phase        = PH_HEADER;
            pr_type         = '0;
            pr_count_left   = '0;
            pr_payload_left = '0;
            pr_last_bit     = 1'b0;
            pr_halted       = 1'b0;
        end
        if (pr_halted) return 1'b0;
        case (pr_phase)
            PH_COUNT: begin
                pr_payload_left = {pr_payload_left[COUNT_W-9:0], d};
                pr_count_left   = pr_count_left - 1'b1;
                if (pr_count_left != 0) return 1'b0;
                pr_phase = (pr_payload_left != 0) ? PH_PAYLOAD : PH_HEADER;
                r.stype  = pr_type;
                if (pr_type == TYPE_END) begin
                    r.kind = K_END;
                    return 1'b1;
                end
                if (pr_type > TYPE_GAP) begin
                    r.kind = K_SKIP;
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_PAYLOAD: begin
                pr_payload_left = pr_payload_left - 1;
                if (pr_payload_left == 0) pr_phase = PH_HEADER;
                r.stype = pr_type;
                if (pr_type == TYPE_MARK) begin
                    r.kind      = K_MARK;
                    r.word      = {8'h00, d};
                    pr_last_bit = d[0];
                    return 1'b1;
                end
                if (pr_type == TYPE_DATA || pr_type == TYPE_GAP) begin
                    r.kind      = K_WORD;
                    r.word      = mfm_word(d, pr_last_bit);
                    pr_last_bit = d[0];
                    return 1'b1;
                end
                return 1'b0;
            end
            default: begin
                size            = d[7:5];
                pr_type         = d[4:0];
                pr_payload_left = '0;
                pr_count_left   = '0;
                r.stype         = pr_type;
                if (size == SIZE_NONE) begin
                    pr_phase = PH_HEADER;
                    if (pr_type == TYPE_END) begin
                        r.kind = K_END;
                        return 1'b1;
                    end
                    pr_halted = 1'b1;
                    r.kind    = K_ZEROSIZE;
                    return 1'b1;
                end
                if (size == SIZE_ONE || size == SIZE_TWO || size == SIZE_FOUR) begin
                    pr_count_left = size;
                    pr_phase      = PH_COUNT;
                    return 1'b0;
                end
                pr_phase  = PH_HEADER;
                pr_halted = 1'b1;
                r.kind    = K_BADSIZE;
                return 1'b1;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        if (errors < PRINT_CAP)
            $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want_v, got_v);
        errors++;
    endtask

    // Predict on each accepted request, check each accepted result
    always @(posedge i_clk) begin : scoreboard
        t_result pred;
        t_result want;
        logic    has;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                has = mfm_predict_byte(i_in_byte, i_stream_start, pred);
                n_accepted++;
                if (req_cur.fixed) begin
                    has        = req_cur.has_result;
                    pred.kind  = req_cur.kind;
                    pred.word  = req_cur.word;
                    pred.stype = req_cur.stype;
                end
                if (has) mfm_expect_q.push_back(pred);
            end
            if (o_out_valid && !i_out_stall) begin
                if (o_kind < 6) kind_seen[o_kind]++;
                if (mfm_expect_q.size() == 0) begin
                    report_mismatch("unexpected result kind", 0, o_kind);
                end else begin
                    want = mfm_expect_q.pop_front();
                    n_checked++;
                    if (o_kind !== want.kind) report_mismatch("kind", want.kind, o_kind);
                    if (o_word !== want.word) report_mismatch("word", want.word, o_word);
                    if (o_sample_kind !== want.stype)
                        report_mismatch("sample_kind", want.stype, o_sample_kind);
                end
            end
        end
    end

    // Output stall pattern and run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles[7:0] == 8'd0) out_calm <= ($urandom_range(0, 3) == 0);
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!out_calm && $urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b0;
        end
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycles, mfm_expect_q.size());
            $display("ipf_sample_stream_to_mfm_test: errors");
            $finish;
        end
    end

    function automatic t_request make_req(input logic [BYTE_W-1:0] d, input logic s);
        make_req       = '0;
        make_req.data  = d;
        make_req.start = s;
    endfunction

    function automatic t_request make_fixed(input logic [BYTE_W-1:0] d, input logic s,
                                            input logic has, input t_kind k,
                                            input logic [WORD_W-1:0] w,
                                            input logic [TYPE_W-1:0] t);
        make_fixed            = make_req(d, s);
        make_fixed.fixed      = 1'b1;
        make_fixed.has_result = has;
        make_fixed.kind       = k;
        make_fixed.word       = w;
        make_fixed.stype      = t;
    endfunction

    // Hold the request until accepted, then maybe drop valid for a while
    task automatic send(input t_request rq);
        int gap;
        int r;
        i_in_valid     <= 1'b1;
        i_in_byte      <= rq.data;
        i_stream_start <= rq.start;
        req_cur        <= rq;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_sent++;
        r   = $urandom_range(0, 99);
        gap = in_calm ? 0 : (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3)
                                                    : $urandom_range(10, 40);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_sample();
        int                 r;
        int                 x;
        int                 n_count;
        int                 n_pay;
        logic               st;
        logic               cut;
        logic [SIZE_W-1:0]  sz;
        logic [TYPE_W-1:0]  typ;
        logic [COUNT_W-1:0] cnt;
        if ($urandom_range(0, 14) == 0) in_calm = !in_calm;
        st           = need_restart || ($urandom_range(0, 19) == 0);
        need_restart = 1'b0;
        r            = $urandom_range(0, 99);
        if (r >= 94) begin
            // malformed header, then a few bytes the halted block drops
            if ($urandom_range(0, 1) == 1) begin
                sz  = SIZE_NONE;
                typ = TYPE_W'($urandom_range(1, 31));
            end else begin
                case ($urandom_range(0, 3))
                    0: sz = 3'd3;
                    1: sz = 3'd5;
                    2: sz = 3'd6;
                    default: sz = 3'd7;
                endcase
                typ = TYPE_W'($urandom_range(0, 31));
            end
            send(make_req({sz, typ}, st));
            x = $urandom_range(0, 3);
            repeat (x) send(make_req(BYTE_W'($urandom_range(0, 255)), 1'b0));
            n_noise += x;
            need_restart = 1'b1;
            return;
        end
        if (r < 8) begin
            send(make_req({SIZE_NONE, TYPE_END}, st));
            return;
        end
        cut = (r >= 88);
        if (r < 78 || cut) begin
            typ = TYPE_W'($urandom_range(1, 3));
        end else begin
            typ = TYPE_W'($urandom_range(3, 31));
            if (typ == TYPE_GAP) typ = TYPE_END;
        end
        case ($urandom_range(0, 2))
            0: sz = SIZE_ONE;
            1: sz = SIZE_TWO;
            default: sz = SIZE_FOUR;
        endcase
        if (cut) begin
            cnt = $urandom;
            if (sz == SIZE_ONE) cnt = cnt & 32'h0000_00ff;
            if (sz == SIZE_TWO) cnt = cnt & 32'h0000_ffff;
            n_count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, sz - 1) : sz;
            n_pay   = (n_count == sz) ? $urandom_range(0, 6) : 0;
            if (cnt < n_pay) n_pay = cnt;
        end else begin
            x       = $urandom_range(0, 29);
            cnt     = (x == 0) ? 0 : (x == 1) ? 255 : $urandom_range(1, 8);
            n_count = sz;
            n_pay   = cnt;
        end
        send(make_req({sz, typ}, st));
        for (int i = int'(sz) - 1; i >= int'(sz) - n_count; i--)
            send(make_req(cnt[8*i +: 8], 1'b0));
        repeat (n_pay) send(make_req(BYTE_W'($urandom_range(0, 255)), 1'b0));
        // restart the parser on the next header after a cut sample
        if (cut) need_restart = 1'b1;
    endtask

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: headers of every known type and count size, extremes of payload
        dir_table.push_back(make_fixed(8'h00, 1'b1, 1'b1, K_END, 16'h0000, TYPE_END));
        dir_table.push_back(make_fixed(8'h01, 1'b0, 1'b1, K_ZEROSIZE, 16'h0000, TYPE_MARK));
        dir_table.push_back(make_fixed(8'hff, 1'b0, 1'b0, K_MARK, 16'h0000, 5'd0));
        dir_table.push_back(make_fixed(8'he7, 1'b1, 1'b1, K_BADSIZE, 16'h0000, 5'd7));
        dir_table.push_back(make_fixed(8'h21, 1'b1, 1'b0, K_MARK, 16'h0000, 5'd0));
        dir_table.push_back(make_fixed(8'h02, 1'b0, 1'b0, K_MARK, 16'h0000, 5'd0));
        dir_table.push_back(make_fixed(8'h00, 1'b0, 1'b1, K_MARK, 16'h0000, TYPE_MARK));
        dir_table.push_back(make_fixed(8'hff, 1'b0, 1'b1, K_MARK, 16'h00ff, TYPE_MARK));
        dir_table.push_back(make_req(8'h42, 1'b0));
        dir_table.push_back(make_req(8'h00, 1'b0));
        dir_table.push_back(make_req(8'h03, 1'b0));
        dir_table.push_back(make_req(8'h00, 1'b0));
        dir_table.push_back(make_req(8'hff, 1'b0));
        dir_table.push_back(make_req(8'h5a, 1'b0));
        dir_table.push_back(make_req(8'h23, 1'b0));
        dir_table.push_back(make_req(8'h00, 1'b0));
        dir_table.push_back(make_req(8'h80, 1'b0));
        dir_table.push_back(make_req(8'h00, 1'b0));
        dir_table.push_back(make_req(8'h00, 1'b0));
        dir_table.push_back(make_req(8'h00, 1'b0));
        dir_table.push_back(make_fixed(8'h01, 1'b0, 1'b1, K_END, 16'h0000, TYPE_END));
        dir_table.push_back(make_fixed(8'h77, 1'b0, 1'b0, K_MARK, 16'h0000, 5'd0));
        dir_table.push_back(make_req(8'h3f, 1'b0));
        dir_table.push_back(make_fixed(8'h00, 1'b0, 1'b1, K_SKIP, 16'h0000, 5'd31));
        dir_table.push_back(make_fixed(8'ha2, 1'b0, 1'b1, K_BADSIZE, 16'h0000, TYPE_DATA));
        dir_table.push_back(make_fixed(8'hc3, 1'b1, 1'b1, K_BADSIZE, 16'h0000, TYPE_GAP));
        foreach (dir_table[k]) send(dir_table[k]);

        need_restart = 1'b1;
        while (n_sent - n_noise < ITEM_TARGET + dir_table.size()) send_sample();

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (mfm_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests and %0d checked results in %0d cycles",
                 n_accepted, n_checked, cycles);
        $display("results by kind: mark %0d, word %0d, end %0d, bad size %0d, %s %0d, skip %0d",
                 kind_seen[K_MARK], kind_seen[K_WORD], kind_seen[K_END],
                 kind_seen[K_BADSIZE], "zero size", kind_seen[K_ZEROSIZE],
                 kind_seen[K_SKIP]);
        if (errors == 0 && mfm_expect_q.size() == 0) begin
            $display("ipf_sample_stream_to_mfm_test: clean");
        end else begin
            $display("ipf_sample_stream_to_mfm_test: errors");
        end
        $finish;
    end

endmodule
